[src/gnf_pkg.sv]
// Shared types, constants and arithmetic helpers for the 1-D gradient noise FBM block.
package gnf_pkg;

    localparam logic [63:0] HASH_MUL = 64'h2545F4914F6CDD1D;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [2:0] REG_SEED       = 3'd0;
    localparam logic [2:0] REG_CURVE_MODE = 3'd1;
    localparam logic [2:0] REG_AMPLITUDE  = 3'd2;
    localparam logic [2:0] REG_FREQUENCY  = 3'd3;
    localparam logic [2:0] REG_OCT_COUNT  = 3'd4;
    localparam logic [2:0] REG_LACUNARITY = 3'd5;
    localparam logic [2:0] REG_OCT_GAIN   = 3'd6;

    localparam logic [1:0] EASE_LINEAR  = 2'd0;
    localparam logic [1:0] EASE_CUBIC   = 2'd1;
    localparam logic [1:0] EASE_QUINTIC = 2'd2;

    typedef struct packed {
        logic [63:0] seed;
        logic [1:0]  curve_mode;
        logic [16:0] octave_gain;
        logic [23:0] lacunarity;
    } gnf_cfg_t;

    function automatic logic [63:0] xorshift(input logic [63:0] v);
        logic [63:0] a;
        logic [63:0] b;
        a = v ^ (v >> 12);
        b = a ^ (a << 25);
        return b ^ (b >> 27);
    endfunction

endpackage

[src/gradient_noise_fbm_1d.sv]
// Top level of the 1-D gradient noise fractional Brownian motion block.
// Accepts one position per cycle while m_axis is not stalled and returns one noise_sum
// per position in order. A result passes through the entry register, the seven-stage
// octave pipeline repeated once per octave and the saturating output register.
// A stall on m_axis holds the whole pipeline; s_axis_tready follows m_axis_tready or an
// empty output register.
module gradient_noise_fbm_1d
    import gnf_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] position
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [39:0] noise_sum
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int CW = $clog2(MAX_OCTAVES + 1);

    logic [63:0] seed_reg;
    logic [1:0]  curve_reg;
    logic [23:0] amp_reg;
    logic [23:0] freq_reg;
    logic [3:0]  count_reg;
    logic [23:0] lac_reg;
    logic [16:0] gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= '0;
            curve_reg <= EASE_LINEAR;
            amp_reg   <= 24'd65536;
            freq_reg  <= 24'd65536;
            count_reg <= 4'd1;
            lac_reg   <= 24'd131072;
            gain_reg  <= 17'd32768;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SEED:       seed_reg  <= cfg_data;
                REG_CURVE_MODE: curve_reg <= cfg_data[1:0];
                REG_AMPLITUDE:  amp_reg   <= cfg_data[23:0];
                REG_FREQUENCY:  freq_reg  <= cfg_data[23:0];
                REG_OCT_COUNT:  count_reg <= cfg_data[3:0];
                REG_LACUNARITY: lac_reg   <= cfg_data[23:0];
                REG_OCT_GAIN:   gain_reg  <= cfg_data[16:0];
                default:        ;
            endcase
        end
    end

    gnf_cfg_t cfg;
    assign cfg.seed        = seed_reg;
    assign cfg.curve_mode  = curve_reg;
    assign cfg.octave_gain = gain_reg;
    assign cfg.lacunarity  = lac_reg;

    logic adv;
    assign adv = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = adv;

    // entry stage
    logic          v0_reg;
    logic [63:0]   x0_reg;
    logic [CW-1:0] n0_reg;
    logic [CW-1:0] ncl;
    logic signed [56:0] px;
    assign ncl = ({1'b0, count_reg} > 5'(MAX_OCTAVES)) ? CW'(MAX_OCTAVES) : CW'(count_reg);
    assign px = 57'($signed(s_axis_tdata)) * 57'($signed({1'b0, freq_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg <= 64'(px >>> 16);
            n0_reg <= ncl;
        end
    end

    logic               v_s  [MAX_OCTAVES+1];
    logic [63:0]        x_s  [MAX_OCTAVES+1];
    logic [39:0]        a_s  [MAX_OCTAVES+1];
    logic signed [63:0] s_s  [MAX_OCTAVES+1];
    logic [CW-1:0]      n_s  [MAX_OCTAVES+1];

    assign v_s[0]   = v0_reg;
    assign x_s[0]   = x0_reg;
    assign a_s[0]   = 40'(amp_reg);
    assign s_s[0]   = '0;
    assign n_s[0]   = n0_reg;

    // octave count travels in a delay line alongside the octave stages
    logic [CW-1:0] nd_reg [MAX_OCTAVES][7];

    for (genvar k = 0; k < MAX_OCTAVES; k++)
    begin : g_oct
        gnf_octave u_oct (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .cfg       (cfg),
            .in_valid  (v_s[k]),
            .in_active (n_s[k] > CW'(k)),
            .in_x      (x_s[k]),
            .in_amp    (a_s[k]),
            .in_sum    (s_s[k]),
            .out_valid (v_s[k+1]),
            .out_x     (x_s[k+1]),
            .out_amp   (a_s[k+1]),
            .out_sum   (s_s[k+1])
        );
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                nd_reg[k][0] <= n_s[k];
                for (int j = 1; j < 7; j++)
                    nd_reg[k][j] <= nd_reg[k][j-1];
            end
        end
        assign n_s[k+1] = nd_reg[k][6];
    end

    // output register with saturation
    logic        ov_reg;
    logic [39:0] od_reg;
    logic signed [63:0] fs;
    assign fs = s_s[MAX_OCTAVES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= v_s[MAX_OCTAVES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (fs > 64'sd549755813887)
                od_reg <= 40'h7FFFFFFFFF;
            else if (fs < -64'sd549755813888)
                od_reg <= 40'h8000000000;
            else
                od_reg <= fs[39:0];
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (m_axis_tready || !m_axis_tvalid))
        else $error("ready not tied to output slot");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> m_axis_tvalid == $past(v_s[MAX_OCTAVES]))
        else $error("valid lost at output");

endmodule

[src/gnf_octave.sv]
// One octave pipeline stage group: lattice hash, slope, blend weight and accumulate.
module gnf_octave
    import gnf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  gnf_cfg_t           cfg,
    input  logic               in_valid,
    input  logic               in_active,
    input  logic [63:0]        in_x,
    input  logic [39:0]        in_amp,
    input  logic signed [63:0] in_sum,
    output logic               out_valid,
    output logic [63:0]        out_x,
    output logic [39:0]        out_amp,
    output logic signed [63:0] out_sum
);

    // stage A: xorshift of both keys
    logic [6:0]         v_reg;
    logic [6:0]         v_next;
    logic [5:0]         act_reg;
    logic [5:0]         act_next;

    logic [63:0]        ha0_reg, ha1_reg;
    logic [15:0]        fa_reg;
    logic [39:0]        ampa_reg;
    logic signed [63:0] suma_reg;
    logic [63:0]        xa_reg;

    logic [63:0] k0;
    logic [63:0] k1;
    assign k0 = ({{16{in_x[63]}}, in_x[63:16]}) + cfg.seed;
    assign k1 = k0 + 64'd1;

    assign v_next   = {v_reg[5:0], in_valid};
    assign act_next = {act_reg[4:0], in_active};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            act_reg <= '0;
        end
        else if (adv)
        begin
            v_reg   <= v_next;
            act_reg <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ha0_reg  <= xorshift(k0);
            ha1_reg  <= xorshift(k1);
            fa_reg   <= in_x[15:0];
            ampa_reg <= in_amp;
            suma_reg <= in_sum;
            xa_reg   <= in_x;
        end
    end

    // stage B: hash multiply partials, f^2, x*lacunarity partials
    logic [63:0]        p0lo_reg, p1lo_reg;
    logic [31:0]        p0cr_reg, p1cr_reg;
    logic [15:0]        fb_reg;
    logic [31:0]        f2b_reg;
    logic [39:0]        ampb_reg;
    logic signed [63:0] sumb_reg;
    logic [55:0]        lob_reg;
    logic [55:0]        hib_reg;
    logic               xsb_reg;
    logic [31:0]        h0ca, h0cb, h1ca, h1cb;
    assign h0ca = ha0_reg[31:0] * HASH_MUL[63:32];
    assign h0cb = ha0_reg[63:32] * HASH_MUL[31:0];
    assign h1ca = ha1_reg[31:0] * HASH_MUL[63:32];
    assign h1cb = ha1_reg[63:32] * HASH_MUL[31:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0lo_reg <= 64'(ha0_reg[31:0]) * 64'(HASH_MUL[31:0]);
            p1lo_reg <= 64'(ha1_reg[31:0]) * 64'(HASH_MUL[31:0]);
            p0cr_reg <= h0ca + h0cb;
            p1cr_reg <= h1ca + h1cb;
            fb_reg   <= fa_reg;
            f2b_reg  <= 32'(fa_reg) * 32'(fa_reg);
            ampb_reg <= ampa_reg;
            sumb_reg <= suma_reg;
            lob_reg  <= 56'(xa_reg[31:0]) * 56'(cfg.lacunarity);
            hib_reg  <= 56'(xa_reg[63:32]) * 56'(cfg.lacunarity);
            xsb_reg  <= xa_reg[63];
        end
    end

    // stage C: slopes, next x
    logic [16:0]        s0c_reg, s1c_reg;
    logic [15:0]        fc_reg;
    logic [31:0]        f2c_reg;
    logic [39:0]        ampc_reg;
    logic signed [63:0] sumc_reg;
    logic [63:0]        xc_reg;
    logic [63:0]        h0m;
    logic [63:0]        h1m;
    logic [63:0]        xn;
    assign h0m = p0lo_reg + {p0cr_reg, 32'd0};
    assign h1m = p1lo_reg + {p1cr_reg, 32'd0};
    assign xn = 64'(lob_reg >> 16) + {hib_reg[47:0], 16'd0}
              - (xsb_reg ? {cfg.lacunarity[15:0], 48'd0} : 64'd0);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0c_reg  <= h0m[63:47];
            s1c_reg  <= h1m[63:47];
            fc_reg   <= fb_reg;
            f2c_reg  <= f2b_reg;
            ampc_reg <= ampb_reg;
            sumc_reg <= sumb_reg;
            xc_reg   <= xn;
        end
    end

    // stage D: y0, y1, weight pieces
    logic signed [35:0] y0d_reg, y1d_reg;
    logic [19:0]        wkd_reg;
    logic [31:0]        md_reg;
    logic [39:0]        ampd_reg;
    logic signed [63:0] sumd_reg;
    logic [63:0]        xd_reg;
    logic signed [17:0] s0, s1;
    logic [63:0]        kcub;
    logic [63:0]        pq;
    logic [63:0]        t3;
    assign s0 = $signed({1'b0, s0c_reg}) - $signed({1'b0, ONE_Q16});
    assign s1 = $signed({1'b0, s1c_reg}) - $signed({1'b0, ONE_Q16});
    assign kcub = 64'd196608 - 64'({fc_reg, 1'b0});
    assign pq = 64'd6 * 64'(f2c_reg) - 64'd983040 * 64'(fc_reg) + (64'd10 << 32);
    assign t3 = (64'(f2c_reg) * 64'(fc_reg)) >> 16;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y0d_reg <= 36'(s0) * 36'($signed({1'b0, fc_reg}));
            y1d_reg <= 36'(s1) * (36'($signed({1'b0, fc_reg})) - 36'sd65536);
            case (cfg.curve_mode)
                EASE_CUBIC:
                begin
                    wkd_reg <= 20'(kcub);
                    md_reg  <= f2c_reg;
                end
                EASE_QUINTIC:
                begin
                    wkd_reg <= 20'(pq >> 16);
                    md_reg  <= 32'(t3);
                end
                default:
                begin
                    wkd_reg <= 20'(fc_reg);
                    md_reg  <= f2c_reg;
                end
            endcase
            ampd_reg <= ampc_reg;
            sumd_reg <= sumc_reg;
            xd_reg   <= xc_reg;
        end
    end

    // stage E: blend weight
    logic [16:0]        ae_reg;
    logic signed [35:0] y0e_reg, y1e_reg;
    logic [39:0]        ampe_reg;
    logic signed [63:0] sume_reg;
    logic [63:0]        xe_reg;
    logic [51:0]        wprod;
    assign wprod = 52'(wkd_reg) * 52'(md_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            case (cfg.curve_mode)
                EASE_CUBIC, EASE_QUINTIC: ae_reg <= 17'(wprod >> 32);
                default:                  ae_reg <= wkd_reg[16:0];
            endcase
            y0e_reg  <= y0d_reg;
            y1e_reg  <= y1d_reg;
            ampe_reg <= ampd_reg;
            sume_reg <= sumd_reg;
            xe_reg   <= xd_reg;
        end
    end

    // stage F: blend and amplitude step
    logic signed [19:0] r16f_reg;
    logic [39:0]        ampf_reg;
    logic [39:0]        ampn_f_reg;
    logic signed [63:0] sumf_reg;
    logic [63:0]        xf_reg;
    logic signed [36:0] dy;
    logic signed [55:0] dprod;
    logic signed [47:0] rb;
    logic [56:0]        amp_gain;
    assign dy = 37'(y1e_reg) - 37'(y0e_reg);
    assign dprod = 56'(dy) * 56'($signed({1'b0, ae_reg}));
    assign rb = 48'(y0e_reg) + 48'(dprod >>> 16);
    assign amp_gain = 57'(ampe_reg) * 57'(cfg.octave_gain);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r16f_reg   <= 20'(rb >>> 16);
            ampf_reg   <= ampe_reg;
            ampn_f_reg <= 40'(amp_gain >> 16);
            sumf_reg   <= sume_reg;
            xf_reg     <= xe_reg;
        end
    end

    // stage G: weighted accumulate
    logic signed [60:0] prod;
    logic signed [63:0] sumg_reg;
    logic [63:0]        xg_reg;
    logic [39:0]        ampg_reg;
    assign prod = 61'(r16f_reg) * 61'($signed({1'b0, ampf_reg}));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sumg_reg <= act_reg[5] ? sumf_reg + 64'(prod >>> 16) : sumf_reg;
            xg_reg   <= xf_reg;
            ampg_reg <= ampn_f_reg;
        end
    end

    assign out_valid = v_reg[6];
    assign out_x     = xg_reg;
    assign out_amp   = ampg_reg;
    assign out_sum   = sumg_reg;

endmodule
